/* src/label_box_overlap_checker_core_macros.svh */
// Assertion helpers for the label box overlap checker.
// Each macro expects clk and rst_n in scope.
`ifndef LABEL_BOX_OVERLAP_CHECKER_CORE_MACROS_SVH
`define LABEL_BOX_OVERLAP_CHECKER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LBOC_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lboc same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LBOC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lboc next-cycle check failed");

`endif

/* src/lboc_pkg.sv */
`default_nettype none

package lboc_pkg;

    localparam int MAX_LABELS    = 1024;
    localparam int IDX_W         = $clog2(MAX_LABELS);
    localparam int CNT_W         = $clog2(MAX_LABELS + 1);
    localparam int LABELS_SEEN_W = 11;
    localparam int POS_W         = 17;

    localparam logic [2:0] CORNER_NONE         = 3'd0;
    localparam logic [2:0] CORNER_BOTTOM_LEFT  = 3'd1;
    localparam logic [2:0] CORNER_TOP_LEFT     = 3'd2;
    localparam logic [2:0] CORNER_TOP_RIGHT    = 3'd3;
    localparam logic [2:0] CORNER_BOTTOM_RIGHT = 3'd4;

    typedef struct packed {
        logic signed [15:0] point_x;
        logic signed [15:0] point_y;
        logic [14:0]        box_length;
        logic [14:0]        box_height;
        logic [2:0]         corner_code;
        logic               last_label;
    } in_word_t;

    typedef struct packed {
        logic                     no_overlap;
        logic [LABELS_SEEN_W-1:0] labels_seen;
        logic                     capacity_exceeded;
    } out_word_t;

    typedef struct packed {
        logic signed [POS_W-1:0] left;
        logic signed [POS_W-1:0] top;
        logic [14:0]             width;
        logic [14:0]             height;
        logic                    placed;
    } entry_t;

    typedef struct packed {
        logic load;
        logic rd_en;
        logic write_entry;
        logic set_overflow;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic placed;
        logic count_zero;
        logic scan_last;
        logic last;
    } dp_status_t;

endpackage

`default_nettype wire

/* src/lboc_datapath.sv */
`default_nettype none

module lboc_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  lboc_pkg::dp_cmd_t    cmd,
    input  lboc_pkg::in_word_t   label,
    output lboc_pkg::dp_status_t status,
    output lboc_pkg::out_word_t  result
);

    lboc_pkg::entry_t entry_mem [lboc_pkg::MAX_LABELS];

    lboc_pkg::in_word_t            item_reg;
    lboc_pkg::entry_t              rd_data_reg;
    lboc_pkg::out_word_t           result_reg;
    logic                          rd_valid_reg;
    logic [lboc_pkg::CNT_W-1:0]    count_reg;
    logic [lboc_pkg::IDX_W-1:0]    idx_reg;
    logic                          overlap_reg;
    logic                          overflow_reg;

    logic                          new_placed;
    logic signed [lboc_pkg::POS_W-1:0] new_left;
    logic signed [lboc_pkg::POS_W-1:0] new_top;
    lboc_pkg::entry_t              new_entry;
    logic signed [17:0]            nl, nt, nw, nh, sl, st, sw, sh;
    logic                          boxes_meet;

    assign new_placed = (item_reg.corner_code != lboc_pkg::CORNER_NONE) &&
                        (item_reg.corner_code <= lboc_pkg::CORNER_BOTTOM_RIGHT);

    // Right corners shift the box left by its width; bottom corners raise the top edge.
    always_comb
    begin
        new_left = lboc_pkg::POS_W'(item_reg.point_x);
        new_top  = lboc_pkg::POS_W'(item_reg.point_y);
        if (item_reg.corner_code == lboc_pkg::CORNER_TOP_RIGHT ||
            item_reg.corner_code == lboc_pkg::CORNER_BOTTOM_RIGHT)
        begin
            new_left = lboc_pkg::POS_W'(item_reg.point_x) - $signed({2'b00, item_reg.box_length});
        end
        if (item_reg.corner_code == lboc_pkg::CORNER_BOTTOM_LEFT ||
            item_reg.corner_code == lboc_pkg::CORNER_BOTTOM_RIGHT)
        begin
            new_top = lboc_pkg::POS_W'(item_reg.point_y) + $signed({2'b00, item_reg.box_height});
        end
        if (!new_placed)
        begin
            new_left = '0;
            new_top  = '0;
        end
    end

    always_comb
    begin
        new_entry.left   = new_left;
        new_entry.top    = new_top;
        new_entry.width  = item_reg.box_length;
        new_entry.height = item_reg.box_height;
        new_entry.placed = new_placed;
    end

    always_comb
    begin
        nl = 18'(new_left);
        nt = 18'(new_top);
        nw = $signed({3'b000, item_reg.box_length});
        nh = $signed({3'b000, item_reg.box_height});
        sl = 18'(rd_data_reg.left);
        st = 18'(rd_data_reg.top);
        sw = $signed({3'b000, rd_data_reg.width});
        sh = $signed({3'b000, rd_data_reg.height});
        boxes_meet = (nl < sl + sw) && (nl + nw > sl) &&
                     (nt > st - sh) && (nt - nh < st);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.write_entry)
        begin
            entry_mem[count_reg[lboc_pkg::IDX_W-1:0]] <= new_entry;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= entry_mem[idx_reg];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            item_reg <= label;
        end
        if (cmd.finish)
        begin
            result_reg.no_overlap        <= !overlap_reg;
            result_reg.labels_seen       <= lboc_pkg::LABELS_SEEN_W'(count_reg);
            result_reg.capacity_exceeded <= overflow_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
            count_reg    <= '0;
            idx_reg      <= '0;
            overlap_reg  <= 1'b0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= cmd.rd_en;
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.rd_en)
            begin
                idx_reg <= idx_reg + lboc_pkg::IDX_W'(1);
            end

            if (cmd.finish)
            begin
                count_reg    <= '0;
                overlap_reg  <= 1'b0;
                overflow_reg <= 1'b0;
            end
            else
            begin
                if (cmd.write_entry)
                begin
                    count_reg <= count_reg + lboc_pkg::CNT_W'(1);
                end
                if (cmd.set_overflow)
                begin
                    overflow_reg <= 1'b1;
                end
                // The read issued in the previous cycle is compared here.
                if (rd_valid_reg && rd_data_reg.placed && boxes_meet)
                begin
                    overlap_reg <= 1'b1;
                end
            end
        end
    end

    always_comb
    begin
        status.full       = (count_reg == lboc_pkg::CNT_W'(lboc_pkg::MAX_LABELS));
        status.placed     = new_placed;
        status.count_zero = (count_reg == '0);
        status.scan_last  = ((lboc_pkg::CNT_W'(idx_reg) + lboc_pkg::CNT_W'(1)) == count_reg);
        status.last       = item_reg.last_label;
    end

    assign result = result_reg;

endmodule

`default_nettype wire

/* src/lboc_ctrl.sv */
`default_nettype none

module lboc_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  label_valid,
    output logic                 label_stall,
    output logic                 result_valid,
    input  wire                  result_stall,
    input  lboc_pkg::dp_status_t status,
    output lboc_pkg::dp_cmd_t    cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_WRITE  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       out_free;

    assign out_free    = !out_valid_reg || !result_stall;
    assign label_stall = (state_reg != S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        out_valid_next = out_valid_reg && result_stall;
        unique case (state_reg)
            S_IDLE:
            begin
                if (label_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_DECIDE:
            begin
                priority if (status.full)
                begin
                    cmd.set_overflow = 1'b1;
                    state_next       = status.last ? S_FINISH : S_IDLE;
                end
                else if (status.placed && !status.count_zero)
                begin
                    state_next = S_SCAN;
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_SCAN:
            begin
                cmd.rd_en = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                cmd.write_entry = 1'b1;
                state_next      = status.last ? S_FINISH : S_IDLE;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign result_valid = out_valid_reg;

endmodule

`default_nettype wire

/* src/label_box_overlap_checker_core.sv */
// Label box overlap checker.
// The label channel (label_valid, label_stall, label) takes one word per labelled
// point; the result channel (result_valid, result_stall, result) gives one word
// after each word marked last_label, and nothing for the others.
// A word is taken when its valid is high and its stall is low.
// Each placed box is compared with every box stored earlier in the set, one
// stored entry per cycle from a single-port entry memory with registered read.
// A placed word with stored entries before it goes through the decide state, a scan
// of those entries and the write state before the next word is taken; an unplaced word
// skips the scan, and one past capacity skips both the scan and the write.
// The result is loaded into an output register in the finish state, which follows the
// write state (the decide state when the last word is past capacity); the next set's
// words are accepted while that result waits to be taken.
// If the receiver stalls and a second result is ready, the block holds it and
// stops taking words until the first result is taken.
// Reset empties the set (count and flags cleared) and drops any pending result;
// memory contents are left as they are and are only read after being written.
`default_nettype none
`include "label_box_overlap_checker_core_macros.svh"

module label_box_overlap_checker_core (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 label_valid,
    output logic                label_stall,
    input  lboc_pkg::in_word_t  label,
    output logic                result_valid,
    input  wire                 result_stall,
    output lboc_pkg::out_word_t result
);

    lboc_pkg::dp_cmd_t    cmd;
    lboc_pkg::dp_status_t status;

    lboc_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .label_valid  (label_valid),
        .label_stall  (label_stall),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .cmd          (cmd)
    );

    lboc_datapath u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .label  (label),
        .status (status),
        .result (result)
    );

    `LBOC_ASSERT_NEXT(a_busy_after_accept, label_valid && !label_stall, label_stall)
    `LBOC_ASSERT_NEXT(a_result_after_finish, cmd.finish, result_valid)
    `LBOC_ASSERT_SAME(a_no_write_when_full, cmd.write_entry, !status.full)
    `LBOC_ASSERT_SAME(a_scan_only_placed, cmd.rd_en, status.placed && !status.count_zero)

endmodule

`default_nettype wire

/* test/tb_label_box_overlap_checker_core.sv */
`timescale 1ns / 1ps

module tb_label_box_overlap_checker_core;
    import lboc_pkg::*;

    localparam int IDLE_LIMIT   = 20000;
    localparam int TAIL_CYCLES  = 2 * MAX_LABELS + 50;
    localparam int RANDOM_WORDS = 580;
    localparam int MAX_REPORTS  = 10;

    // Corner codes with no placement meaning; the block treats them as none.
    localparam logic [2:0] CORNER_RSVD5 = 3'd5;
    localparam logic [2:0] CORNER_RSVD6 = 3'd6;
    localparam logic [2:0] CORNER_RSVD7 = 3'd7;

    typedef struct {
        in_word_t  w;
        bit        known;
        out_word_t summary;
    } label_row_t;

    logic      clk;
    logic      rst_n;
    logic      label_valid;
    logic      label_stall;
    in_word_t  label;
    logic      result_valid;
    logic      result_stall;
    out_word_t result;

    entry_t     stored_boxes[$];
    bit         overlap_found;
    bit         overflow_found;
    out_word_t  set_summaries[$];
    label_row_t directed_rows[$];

    int mismatches   = 0;
    int idle_cycles  = 0;
    int random_sent  = 0;
    bit steady_phase = 1'b0;

    label_box_overlap_checker_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .label_valid  (label_valid),
        .label_stall  (label_stall),
        .label        (label),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic in_word_t make_word(int px, int py, int len, int hgt,
                                           logic [2:0] code, bit last);
        in_word_t w;
        w.point_x     = px[15:0];
        w.point_y     = py[15:0];
        w.box_length  = len[14:0];
        w.box_height  = hgt[14:0];
        w.corner_code = code;
        w.last_label  = last;
        return w;
    endfunction

    // Builds the word that puts a box with the given left and top edges
    // through the chosen corner.
    function automatic in_word_t anchor_word(int l, int t, int len, int hgt,
                                             logic [2:0] code, bit last);
        int px;
        int py;
        px = (code == CORNER_TOP_RIGHT || code == CORNER_BOTTOM_RIGHT) ? l + len : l;
        py = (code == CORNER_BOTTOM_LEFT || code == CORNER_BOTTOM_RIGHT) ? t - hgt : t;
        return make_word(px, py, len, hgt, code, last);
    endfunction

    function automatic label_row_t row_of(int px, int py, int len, int hgt,
                                          logic [2:0] code, bit last,
                                          bit known = 1'b0, bit free = 1'b0,
                                          int seen = 0, bit over = 1'b0);
        label_row_t r;
        r.w                         = make_word(px, py, len, hgt, code, last);
        r.known                     = known;
        r.summary.no_overlap        = free;
        r.summary.labels_seen       = LABELS_SEEN_W'(seen);
        r.summary.capacity_exceeded = over;
        return r;
    endfunction

    function automatic logic [2:0] unplaced_code();
        case ($urandom_range(0, 3))
            0: return CORNER_NONE;
            1: return CORNER_RSVD5;
            2: return CORNER_RSVD6;
            default: return CORNER_RSVD7;
        endcase
    endfunction

    function automatic bit boxes_intersect(int al, int at, int aw, int ah,
                                           int bl, int bt, int bw, int bh);
        return al < bl + bw && al + aw > bl && at > bt - bh && at - ah < bt;
    endfunction

    // Places the label, checks it against the boxes of the current set and
    // gives the set summary when the word closes the set.
    function automatic void account_label(input in_word_t w, output bit done,
                                          output out_word_t summary);
        entry_t e;
        int     left;
        int     top;
        int     len;
        int     hgt;
        bit     placed;
        len    = w.box_length;
        hgt    = w.box_height;
        placed = w.corner_code >= CORNER_BOTTOM_LEFT && w.corner_code <= CORNER_BOTTOM_RIGHT;
        left   = 0;
        top    = 0;
        if (placed)
        begin
            left = $signed(w.point_x);
            top  = $signed(w.point_y);
            if (w.corner_code == CORNER_TOP_RIGHT || w.corner_code == CORNER_BOTTOM_RIGHT)
                left = left - len;
            if (w.corner_code == CORNER_BOTTOM_LEFT || w.corner_code == CORNER_BOTTOM_RIGHT)
                top = top + hgt;
        end
        if (stored_boxes.size() < MAX_LABELS)
        begin
            if (placed)
            begin
                foreach (stored_boxes[i])
                begin
                    if (stored_boxes[i].placed &&
                        boxes_intersect(left, top, len, hgt,
                                        $signed(stored_boxes[i].left),
                                        $signed(stored_boxes[i].top),
                                        int'(stored_boxes[i].width),
                                        int'(stored_boxes[i].height)))
                        overlap_found = 1'b1;
                end
            end
            e.left   = left[POS_W-1:0];
            e.top    = top[POS_W-1:0];
            e.width  = w.box_length;
            e.height = w.box_height;
            e.placed = placed;
            stored_boxes.push_back(e);
        end
        else
            overflow_found = 1'b1;
        done                      = w.last_label;
        summary.no_overlap        = !overlap_found;
        summary.labels_seen       = LABELS_SEEN_W'(stored_boxes.size());
        summary.capacity_exceeded = overflow_found;
        if (done)
        begin
            stored_boxes.delete();
            overlap_found  = 1'b0;
            overflow_found = 1'b0;
        end
    endfunction

    function automatic int pick_gap();
        int r;
        if (steady_phase)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Called right after a rising edge; returns at the edge that takes the word.
    // Valid is only lowered when a gap comes, so back-to-back words keep it high.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            label_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        label       <= w;
        label_valid <= 1'b1;
        @(posedge clk);
        while (label_stall)
            @(posedge clk);
    endtask

    task automatic send_label(input in_word_t w);
        bit        done;
        out_word_t s;
        send_word(w);
        account_label(w, done, s);
        if (done)
            set_summaries.push_back(s);
    endtask

    task automatic run_set();
        int         kind;
        int         n;
        int         x0;
        int         y0;
        int         step;
        int         hgt;
        int         len;
        int         bump;
        logic [2:0] code;
        bit         last;
        in_word_t   w;
        kind = $urandom_range(0, 99);
        n    = (kind >= 90) ? $urandom_range(40, 80) : $urandom_range(1, 16);
        x0   = $urandom_range(0, 4000) - 32000;
        y0   = $urandom_range(0, 60000) - 30000;
        step = $urandom_range(1, 100);
        hgt  = $urandom_range(0, 200);
        bump = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n - 1) : -1;
        for (int i = 0; i < n; i++)
        begin
            last = (i == n - 1);
            code = 3'($urandom_range(0, 7));
            if (kind < 40 || kind >= 90)
            begin
                // Small boxes in a narrow window, so overlaps come and go.
                w = make_word(x0 + $urandom_range(0, 300), y0 + $urandom_range(0, 300),
                              $urandom_range(0, 40), $urandom_range(0, 40), code, last);
            end
            else if (kind < 65)
            begin
                // A row of boxes whose edges touch or leave a one-unit gap; the bumped box reaches
                // one unit into its right neighbor.
                len  = (i == bump) ? step + 1 : step - $urandom_range(0, 1);
                code = 3'($urandom_range(1, 4));
                w    = anchor_word(x0 + i * step, y0, len, hgt, code, last);
            end
            else if (kind < 80)
            begin
                w = make_word($urandom_range(0, 65535), $urandom_range(0, 65535),
                              $urandom_range(0, 32767), $urandom_range(0, 32767),
                              code, last);
            end
            else
            begin
                if ($urandom_range(0, 3) != 0)
                    code = unplaced_code();
                w = make_word($urandom, $urandom, $urandom, $urandom, code, last);
            end
            send_label(w);
        end
        random_sent += n;
    endtask

    // One set that fills the entry store, then runs extra words past it.
    // Most words are unplaced so few of them scan the store.
    task automatic fill_store(input int extra);
        int         total;
        logic [2:0] code;
        total = MAX_LABELS + extra;
        for (int i = 0; i < total; i++)
        begin
            if ($urandom_range(0, 49) == 0 || i >= total - 3)
                code = 3'($urandom_range(1, 4));
            else
                code = unplaced_code();
            send_label(make_word($urandom_range(0, 2000) - 1000,
                                 $urandom_range(0, 2000) - 1000,
                                 $urandom_range(0, 40), $urandom_range(0, 40),
                                 code, i == total - 1));
        end
    endtask

    initial
    begin
        int        gap;
        out_word_t want;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                if (set_summaries.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected result word %0b/%0d/%0b",
                                 $time, result.no_overlap, result.labels_seen,
                                 result.capacity_exceeded);
                end
                else
                begin
                    want = set_summaries.pop_front();
                    if (want.no_overlap !== result.no_overlap ||
                        want.labels_seen !== result.labels_seen ||
                        want.capacity_exceeded !== result.capacity_exceeded)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: expected %0b/%0d/%0b got %0b/%0d/%0b",
                                     $time, want.no_overlap, want.labels_seen,
                                     want.capacity_exceeded, result.no_overlap,
                                     result.labels_seen, result.capacity_exceeded);
                    end
                end
            end
            if (gap > 0)
            begin
                result_stall <= 1'b1;
                gap--;
            end
            else
            begin
                gap = pick_gap();
                result_stall <= (gap > 0);
                if (gap > 0)
                    gap--;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((label_valid && !label_stall) || (result_valid && !result_stall))
            idle_cycles <= 0;
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial
    begin
        bit        done;
        out_word_t s;
        rst_n          = 1'b0;
        label_valid    <= 1'b0;
        label          <= '0;
        overlap_found  = 1'b0;
        overflow_found = 1'b0;

        // Single unplaced word right after reset.
        directed_rows.push_back(row_of(0, 0, 0, 0, CORNER_NONE, 1'b1, 1'b1, 1'b1, 1));
        // Extreme anchor and size alone in its set.
        directed_rows.push_back(row_of(-32768, 32767, 32767, 32767, CORNER_TOP_RIGHT,
                                       1'b1, 1'b1, 1'b1, 1));
        // Two identical boxes.
        directed_rows.push_back(row_of(0, 0, 10, 10, CORNER_BOTTOM_LEFT, 1'b0));
        directed_rows.push_back(row_of(0, 0, 10, 10, CORNER_BOTTOM_LEFT, 1'b1,
                                       1'b1, 1'b0, 2));
        // Boxes meeting along edges and at a corner.
        directed_rows.push_back(row_of(0, 0, 10, 10, CORNER_TOP_LEFT, 1'b0));
        directed_rows.push_back(row_of(10, 0, 10, 10, CORNER_TOP_LEFT, 1'b0));
        directed_rows.push_back(row_of(0, 0, 10, 10, CORNER_BOTTOM_RIGHT, 1'b0));
        directed_rows.push_back(row_of(0, -5, 10, 10, CORNER_TOP_RIGHT, 1'b1));
        // Zero-size box inside another.
        directed_rows.push_back(row_of(0, 0, 10, 10, CORNER_TOP_LEFT, 1'b0));
        directed_rows.push_back(row_of(5, -5, 0, 0, CORNER_TOP_LEFT, 1'b1));
        // Unplaced and unknown corners on top of a placed box never collide.
        directed_rows.push_back(row_of(0, 0, 100, 100, CORNER_TOP_LEFT, 1'b0));
        directed_rows.push_back(row_of(0, 0, 100, 100, CORNER_RSVD5, 1'b0));
        directed_rows.push_back(row_of(0, 0, 100, 100, CORNER_RSVD6, 1'b0));
        directed_rows.push_back(row_of(0, 0, 100, 100, CORNER_NONE, 1'b0));
        directed_rows.push_back(row_of(0, 0, 100, 100, CORNER_RSVD7, 1'b1,
                                       1'b1, 1'b1, 5));
        // Four full-size boxes filling the quadrants, one per corner code.
        directed_rows.push_back(row_of(-32768, 32767, 32767, 32767, CORNER_TOP_LEFT, 1'b0));
        directed_rows.push_back(row_of(32767, -32768, 32767, 32767, CORNER_BOTTOM_RIGHT,
                                       1'b0));
        directed_rows.push_back(row_of(-32768, -32768, 32767, 32767, CORNER_BOTTOM_LEFT,
                                       1'b0));
        directed_rows.push_back(row_of(32767, 32767, 32767, 32767, CORNER_TOP_RIGHT, 1'b1,
                                       1'b1, 1'b1, 4));
        // Top edge pushed past the 16-bit range, touching a box below it.
        directed_rows.push_back(row_of(0, 32767, 5, 32767, CORNER_BOTTOM_LEFT, 1'b0));
        directed_rows.push_back(row_of(2, 32767, 5, 1, CORNER_TOP_LEFT, 1'b1));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
        begin
            send_word(directed_rows[i].w);
            account_label(directed_rows[i].w, done, s);
            if (done)
                set_summaries.push_back(directed_rows[i].known ? directed_rows[i].summary : s);
        end

        while (random_sent < RANDOM_WORDS)
        begin
            steady_phase = ($urandom_range(0, 3) == 0);
            run_set();
        end
        steady_phase = 1'b0;
        fill_store(0);
        fill_store($urandom_range(1, 4));
        label_valid <= 1'b0;

        while (set_summaries.size() > 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0 && set_summaries.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
